// ===== design/jsu_pkg.sv =====
package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX0 = 3'd3,
        MODE_HEX1 = 3'd4,
        MODE_HEX2 = 3'd5,
        MODE_HEX3 = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        ST_BUSY    = 2'd0,
        ST_CLOSED  = 2'd1,
        ST_NOQUOTE = 2'd2,
        ST_TRUNC   = 2'd3
    } t_status;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [15:0] CP_TWO     = 16'h0080;
    localparam logic [15:0] CP_THREE   = 16'h0800;

    localparam int unsigned MAX_WORDS = 3;

    typedef struct packed {
        logic [MAX_WORDS-1:0][7:0] data;
        logic [1:0]                cnt;
        logic                      data_ok;
        t_status                   status;
    } t_bundle;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// ===== design/jsu_if.sv =====
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last_of_run;

    modport source (
        output valid, output out_byte, output byte_valid, output status,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input status,
        input last_of_run, output ready
    );
endinterface

// ===== design/jsu_dec.sv =====
module jsu_dec
    import jsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    jsu_in_if.sink  i_in,
    output t_bundle o_bnd,
    output logic    o_bnd_valid,
    input  logic    i_bnd_ready
);

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_eot;
    t_mode       r_mode;
    logic [15:0] r_acc;
    logic        r_stop;

    t_mode       n_mode;
    logic [15:0] n_acc;
    logic        n_stop;
    t_bundle     n_bnd;
    t_hex        hv;
    logic        fire_in;
    logic        consume;

    assign i_in.ready  = !r_in_valid || i_bnd_ready;
    assign fire_in     = i_in.valid && i_in.ready;
    assign consume     = r_in_valid && i_bnd_ready;
    assign o_bnd_valid = r_in_valid;
    assign o_bnd       = n_bnd;

    always_comb begin
        n_mode        = r_mode;
        n_acc         = r_acc;
        n_stop        = r_stop;
        n_bnd         = '0;
        n_bnd.cnt     = 2'd1;
        n_bnd.status  = ST_BUSY;
        hv            = hex_value(r_byte);
        unique case (r_mode)
            MODE_STR, MODE_ESC, MODE_HEX0, MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                if (r_eot) begin
                    n_mode       = MODE_IDLE;
                    n_bnd.status = ST_TRUNC;
                end else if (r_mode == MODE_STR) begin
                    if (r_byte == CH_QUOTE) begin
                        n_mode       = MODE_IDLE;
                        n_bnd.status = ST_CLOSED;
                    end else if (r_byte == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        n_bnd.data[0] = r_byte;
                        n_bnd.data_ok = 1'b1;
                    end
                end else if (r_mode == MODE_ESC) begin
                    n_mode        = MODE_STR;
                    n_bnd.data_ok = 1'b1;
                    unique case (r_byte)
                        CH_N:    n_bnd.data[0] = CTL_LF;
                        CH_R:    n_bnd.data[0] = CTL_CR;
                        CH_T:    n_bnd.data[0] = CTL_HT;
                        CH_B:    n_bnd.data[0] = CTL_BS;
                        CH_F:    n_bnd.data[0] = CTL_FF;
                        CH_U: begin
                            n_mode        = MODE_HEX0;
                            n_acc         = '0;
                            n_stop        = 1'b0;
                            n_bnd.data_ok = 1'b0;
                        end
                        default: n_bnd.data[0] = r_byte;
                    endcase
                end else begin
                    if (!r_stop && hv.ok) begin
                        n_acc = {r_acc[11:0], hv.val};
                    end else begin
                        n_stop = 1'b1;
                    end
                    if (r_mode != MODE_HEX3) begin
                        n_mode = t_mode'(r_mode + 3'd1);
                    end else begin
                        n_mode        = MODE_STR;
                        n_bnd.data_ok = 1'b1;
                        if (n_acc < CP_TWO) begin
                            n_bnd.data[0] = n_acc[7:0];
                        end else if (n_acc < CP_THREE) begin
                            n_bnd.cnt     = 2'd2;
                            n_bnd.data[0] = UTF8_LEAD2 | {3'b000, n_acc[10:6]};
                            n_bnd.data[1] = UTF8_CONT | {2'b00, n_acc[5:0]};
                        end else begin
                            n_bnd.cnt     = 2'd3;
                            n_bnd.data[0] = UTF8_LEAD3 | {4'b0000, n_acc[15:12]};
                            n_bnd.data[1] = UTF8_CONT | {2'b00, n_acc[11:6]};
                            n_bnd.data[2] = UTF8_CONT | {2'b00, n_acc[5:0]};
                        end
                    end
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                if (!r_eot && r_byte == CH_QUOTE) begin
                    n_mode = MODE_STR;
                end else begin
                    n_bnd.status = ST_NOQUOTE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_acc      <= '0;
            r_stop     <= 1'b0;
        end else begin
            if (fire_in) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_mode <= n_mode;
                r_acc  <= n_acc;
                r_stop <= n_stop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_in) begin
            r_byte <= i_in.in_byte;
            r_eot  <= i_in.end_of_text;
        end
    end

endmodule

// ===== design/jsu_ser.sv =====
module jsu_ser
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_bundle   i_bnd,
    input  logic      i_bnd_valid,
    output logic      o_bnd_ready,
    jsu_out_if.source o_out
);

    logic       r_valid;
    t_bundle    r_bnd;
    logic [1:0] r_idx;
    logic       last;
    logic       fire_out;

    assign last        = (r_idx == r_bnd.cnt - 2'd1);
    assign fire_out    = r_valid && o_out.ready;
    assign o_bnd_ready = !r_valid || (fire_out && last);

    assign o_out.valid       = r_valid;
    assign o_out.byte_valid  = r_bnd.data_ok;
    assign o_out.status      = r_bnd.status;
    assign o_out.last_of_run = last;

    always_comb begin
        unique case (r_idx)
            2'd0:    o_out.out_byte = r_bnd.data[0];
            2'd1:    o_out.out_byte = r_bnd.data[1];
            2'd2:    o_out.out_byte = r_bnd.data[2];
            default: o_out.out_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_bnd_ready) begin
            r_valid <= i_bnd_valid;
            r_idx   <= '0;
        end else if (fire_out) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_bnd_ready && i_bnd_valid) begin
            r_bnd <= i_bnd;
        end
    end

endmodule

// ===== design/json_string_unescaper.sv =====
// An accepted word is registered in the decoder, then in the serializer, before its first result word shows.
// Throughput: one result word per cycle while the output is ready; an input word
// makes 1 to 3 result words (three only for a u escape above 0x7FF).
// Reset: synchronous, active low; returns to idle awaiting the opening quote,
// clears the hex accumulator and drops any held word.
module json_string_unescaper
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    t_bundle bnd;
    logic    bnd_valid;
    logic    bnd_ready;

    jsu_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_bnd       (bnd),
        .o_bnd_valid (bnd_valid),
        .i_bnd_ready (bnd_ready)
    );

    jsu_ser u_ser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bnd       (bnd),
        .i_bnd_valid (bnd_valid),
        .o_bnd_ready (bnd_ready),
        .o_out       (o_out)
    );

endmodule
